// ----- hw/rtl/ffaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared types and codes of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffaa_pkg;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_RESIZE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_BAD_ADDRESS = 2'd2
	} status_t;

	// what a hit cell does during a walk
	typedef enum logic [1:0] {
		W_FIT  = 2'd0,
		W_FREE = 2'd1,
		W_RSZ  = 2'd2
	} walk_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_WALK1 = 3'd1,
		S_WALK2 = 3'd2,
		S_WALK3 = 3'd3,
		S_RESP  = 3'd4
	} state_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic split;
		logic absorb;
	} cell_rpt_t;

	localparam int ADDR_W = 11;
	localparam int SIZE_W = 16;
	localparam int DATA_W = 32;

endpackage

// ----- hw/rtl/first_fit_arena_allocator.sv -----
`timescale 1ns / 1ps
// Allocate and release of a nonzero address take one walk of the token along the
// segment cells, one cell per cycle; a moving resize takes three walks. The transfer
// in and the result are registered.
// One item at a time: the next transfer is accepted after the result is taken.
// Reset (arst_n low) and the init operation leave one free segment over the arena.
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit segment allocator over a chain of segment cells.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator #(
	parameter int ARENA_BYTES  = 2048,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_SEGMENTS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ffaa_pkg::DATA_W-1:0]   s_tdata,  // address[10:0], req_size[26:11], zero pad
	input  logic [1:0]                    s_tuser,  // operation[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffaa_pkg::DATA_W-1:0]   m_tdata   // result_address[10:0], status[12:11],
	                                                // moved[13], copy_length[24:14], zero pad
);
	import ffaa_pkg::*;

	localparam int LW = $clog2(ARENA_BYTES + 1);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int XW = (LW > SIZE_W ? LW : SIZE_W) + 2;
	localparam int N  = MAX_SEGMENTS;

	state_t              state_q, state_d;
	walk_t               mode_q, mode_d;
	logic [ADDR_W-1:0]   addr_q, res_q, res_d, copy_q, copy_d, new_res_q;
	logic [SIZE_W-1:0]   size_q;
	status_t             status_q, status_d;
	logic                moved_q, moved_d;
	logic [LW-1:0]       old_len_q;
	logic [CW-1:0]       count_q;
	logic                start_w, init_w, set_res, ld_old, ld_new;
	op_t                 op;
	logic [ADDR_W-1:0]   in_addr;
	logic [SIZE_W-1:0]   in_size;

	logic [N-1:0]        valid_w, free_w, tok_w, hs_w, hit_vec;
	logic [LW-1:0]       start_w_a [N];
	logic [LW-1:0]       len_w_a [N];
	cell_rpt_t           rpt_w [N];
	logic                shr, shl, hit_any, miss_any, done;
	logic [LW-1:0]       hit_start, hit_len;
	logic [ADDR_W-1:0]   hit_addr;

	assign op      = op_t'(s_tuser);
	assign in_addr = s_tdata[ADDR_W-1:0];
	assign in_size = s_tdata[ADDR_W+SIZE_W-1:ADDR_W];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          l_valid, l_free, l_hs, r_valid, r_free, t_in;
		logic [LW-1:0] l_start, l_len, r_start, r_len;
		if (i == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_free  = 1'b0;
			assign l_start = '0;
			assign l_len   = '0;
			assign l_hs    = 1'b0;
			assign t_in    = start_w;
		end else begin : g_mid
			assign l_valid = valid_w[i-1];
			assign l_free  = free_w[i-1];
			assign l_start = start_w_a[i-1];
			assign l_len   = len_w_a[i-1];
			assign l_hs    = hs_w[i-1];
			assign t_in    = tok_w[i-1];
		end
		if (i == N - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_free  = 1'b0;
			assign r_start = '0;
			assign r_len   = '0;
		end else begin : g_inner
			assign r_valid = valid_w[i+1];
			assign r_free  = free_w[i+1];
			assign r_start = start_w_a[i+1];
			assign r_len   = len_w_a[i+1];
		end
		ffaa_cell #(
			.LW    (LW),
			.HDR   (HEADER_BYTES),
			.ARENA (ARENA_BYTES),
			.HEAD  (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.init        (init_w),
			.start       (start_w),
			.mode        (mode_q),
			.not_full    (count_q != CW'(MAX_SEGMENTS)),
			.size        (size_q),
			.addr        (addr_q),
			.shr         (shr),
			.shl         (shl),
			.tok_in      (t_in),
			.left_valid  (l_valid),
			.left_free   (l_free),
			.left_start  (l_start),
			.left_len    (l_len),
			.left_hs     (l_hs),
			.right_valid (r_valid),
			.right_free  (r_free),
			.right_start (r_start),
			.right_len   (r_len),
			.tok_out     (tok_w[i]),
			.valid       (valid_w[i]),
			.free        (free_w[i]),
			.seg_start   (start_w_a[i]),
			.seg_len     (len_w_a[i]),
			.hit_split   (hs_w[i]),
			.rpt         (rpt_w[i])
		);
		assign hit_vec[i] = rpt_w[i].hit;
	end

	// one-hot collection of the hit cell
	always_comb begin
		shr       = 1'b0;
		shl       = 1'b0;
		miss_any  = tok_w[N-1];
		hit_start = '0;
		hit_len   = '0;
		for (int i = 0; i < N; i++) begin
			shr      = shr | rpt_w[i].split;
			shl      = shl | rpt_w[i].absorb;
			miss_any = miss_any | rpt_w[i].miss;
			hit_start = hit_start | (rpt_w[i].hit ? start_w_a[i] : '0);
			hit_len   = hit_len | (rpt_w[i].hit ? len_w_a[i] : '0);
		end
		hit_any  = |hit_vec;
		done     = hit_any | miss_any;
		hit_addr = ADDR_W'(XW'(hit_start) + XW'(HEADER_BYTES));
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		start_w  = 1'b0;
		init_w   = 1'b0;
		set_res  = 1'b0;
		ld_old   = 1'b0;
		ld_new   = 1'b0;
		res_d    = '0;
		status_d = ST_OK;
		moved_d  = 1'b0;
		copy_d   = '0;
		s_tready = (state_q == S_IDLE);
		m_tvalid = (state_q == S_RESP);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (op)
						OP_INIT: begin
							init_w  = 1'b1;
							set_res = 1'b1;
							state_d = S_RESP;
						end
						OP_ALLOC: begin
							mode_d  = W_FIT;
							start_w = 1'b1;
							state_d = S_WALK1;
						end
						OP_RELEASE: begin
							if (in_addr == '0) begin
								set_res = 1'b1;
								state_d = S_RESP;
							end else begin
								mode_d  = W_FREE;
								start_w = 1'b1;
								state_d = S_WALK1;
							end
						end
						OP_RESIZE: begin
							mode_d  = (in_addr == '0) ? W_FIT : W_RSZ;
							start_w = 1'b1;
							state_d = S_WALK1;
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK1: begin
				if (done) begin
					case (mode_q)
						W_FIT: begin
							set_res = 1'b1;
							state_d = S_RESP;
							if (hit_any) begin
								res_d = hit_addr;
							end else begin
								status_d = ST_NO_SPACE;
							end
						end
						W_FREE: begin
							set_res = 1'b1;
							state_d = S_RESP;
							if (!hit_any) begin
								status_d = ST_BAD_ADDRESS;
							end
						end
						W_RSZ: begin
							if (!hit_any) begin
								set_res  = 1'b1;
								status_d = ST_BAD_ADDRESS;
								state_d  = S_RESP;
							end else if (size_q == '0) begin
								set_res = 1'b1;
								state_d = S_RESP;
							end else if ((XW'(hit_len) >= XW'(size_q)) || shl) begin
								set_res = 1'b1;
								res_d   = addr_q;
								state_d = S_RESP;
							end else begin
								ld_old  = 1'b1;
								mode_d  = W_FIT;
								start_w = 1'b1;
								state_d = S_WALK2;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK2: begin
				if (done) begin
					if (hit_any) begin
						ld_new  = 1'b1;
						mode_d  = W_FREE;
						start_w = 1'b1;
						state_d = S_WALK3;
					end else begin
						set_res  = 1'b1;
						status_d = ST_NO_SPACE;
						state_d  = S_RESP;
					end
				end
			end
			S_WALK3: begin
				if (done) begin
					set_res = 1'b1;
					res_d   = new_res_q;
					moved_d = 1'b1;
					copy_d  = ADDR_W'(old_len_q);
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= W_FIT;
			count_q <= CW'(1);
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (init_w) begin
				count_q <= CW'(1);
			end else if (shr) begin
				count_q <= count_q + CW'(1);
			end else if (shl) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_q <= in_addr;
			size_q <= in_size;
		end
		if (set_res) begin
			res_q    <= res_d;
			status_q <= status_d;
			moved_q  <= moved_d;
			copy_q   <= copy_d;
		end
		if (ld_old) begin
			old_len_q <= hit_len;
		end
		if (ld_new) begin
			new_res_q <= hit_addr;
		end
	end

	assign m_tdata = DATA_W'({copy_q, moved_q, status_q, res_q});

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS))
		else $error("segment count beyond table size");
	a_no_dual_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(shr && shl))
		else $error("split and absorb in one cycle");
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell hit");
	a_hit_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		hit_any |-> (state_q == S_WALK1 || state_q == S_WALK2 || state_q == S_WALK3))
		else $error("cell hit outside a walk");

endmodule

// ----- hw/rtl/ffaa_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_cell
// One segment slot: holds a segment, matches the walk token, shifts to insert
// or remove a neighbour.
// ----------------------------------------------------------------------------
module ffaa_cell #(
	parameter int LW     = 12,
	parameter int HDR    = 24,
	parameter int ARENA  = 2048,
	parameter bit HEAD   = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      init,
	input  logic                      start,
	input  ffaa_pkg::walk_t           mode,
	input  logic                      not_full,
	input  logic [ffaa_pkg::SIZE_W-1:0] size,
	input  logic [ffaa_pkg::ADDR_W-1:0] addr,
	input  logic                      shr,
	input  logic                      shl,
	input  logic                      tok_in,
	input  logic                      left_valid,
	input  logic                      left_free,
	input  logic [LW-1:0]             left_start,
	input  logic [LW-1:0]             left_len,
	input  logic                      left_hs,
	input  logic                      right_valid,
	input  logic                      right_free,
	input  logic [LW-1:0]             right_start,
	input  logic [LW-1:0]             right_len,
	output logic                      tok_out,
	output logic                      valid,
	output logic                      free,
	output logic [LW-1:0]             seg_start,
	output logic [LW-1:0]             seg_len,
	output logic                      hit_split,
	output ffaa_pkg::cell_rpt_t       rpt
);
	import ffaa_pkg::*;

	localparam int XW = (LW > SIZE_W ? LW : SIZE_W) + 2;

	logic          valid_q, free_q, tok_q, passed_q;
	logic [LW-1:0] start_q, len_q;
	logic [XW-1:0] len_x, size_x, hdr_x;
	logic          fit, split_ok, addr_hit, match, hit, absorb;

	always_comb begin
		len_x    = XW'(len_q);
		size_x   = XW'(size);
		hdr_x    = XW'(HDR);
		fit      = len_x >= size_x;
		split_ok = not_full && (len_x >= size_x + hdr_x + XW'(1));
		addr_hit = (XW'(start_q) + hdr_x) == XW'(addr);
		match    = (mode == W_FIT) ? (free_q && fit) : addr_hit;
		hit      = tok_q && valid_q && match;
		absorb   = (mode == W_RSZ) && right_valid && right_free && (size != '0) && !fit &&
			(len_x + hdr_x + XW'(right_len) >= size_x);
		tok_out  = tok_q && valid_q && !match;
		hit_split = hit && (mode == W_FIT) && split_ok;
		rpt.hit    = hit;
		rpt.miss   = tok_q && !valid_q;
		rpt.split  = hit_split;
		rpt.absorb = hit && absorb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= HEAD;
			free_q   <= 1'b1;
			start_q  <= '0;
			len_q    <= LW'(ARENA - HDR);
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
		end else if (init) begin
			valid_q  <= HEAD;
			free_q   <= 1'b1;
			start_q  <= '0;
			len_q    <= LW'(ARENA - HDR);
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (start) begin
				passed_q <= 1'b0;
			end else if (tok_out) begin
				passed_q <= 1'b1;
			end
			if (hit) begin
				case (mode)
					W_FIT: begin
						free_q <= 1'b0;
						if (split_ok) begin
							len_q <= LW'(size_x);
						end
					end
					W_FREE: begin
						free_q <= 1'b1;
					end
					W_RSZ: begin
						if (size == '0) begin
							free_q <= 1'b1;
						end else if (absorb) begin
							len_q <= LW'(len_x + hdr_x + XW'(right_len));
						end
					end
					default: begin
					end
				endcase
			end else if (shr && !passed_q && !tok_q) begin
				if (left_hs) begin
					valid_q <= 1'b1;
					free_q  <= 1'b1;
					start_q <= LW'(XW'(left_start) + hdr_x + size_x);
					len_q   <= LW'(XW'(left_len) - size_x - hdr_x);
				end else begin
					valid_q <= left_valid;
					free_q  <= left_free;
					start_q <= left_start;
					len_q   <= left_len;
				end
			end else if (shl && !passed_q && !tok_q) begin
				valid_q <= right_valid;
				free_q  <= right_free;
				start_q <= right_start;
				len_q   <= right_len;
			end
		end
	end

	assign valid     = valid_q;
	assign free      = free_q;
	assign seg_start = start_q;
	assign seg_len   = len_q;

endmodule

// ----- tb/sv/tb_first_fit_arena_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_arena_allocator
// Drives allocate, release, resize and init requests into the arena
// allocator with random gaps and back-pressure. A local segment-list model
// predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_arena_allocator;
	import ffaa_pkg::*;

	localparam int ARENA   = 2048;
	localparam int HDR     = 24;
	localparam int MAXSEG  = 128;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		op_t         op;
		logic [10:0] addr;
		logic [15:0] size;
	} req_t;

	typedef struct packed {
		logic [10:0] addr;
		status_t     st;
		logic        moved;
		logic [10:0] copy;
	} rsp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [DATA_W-1:0] m_tdata;

	first_fit_arena_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// segment list
	int seg_start [MAXSEG];
	int seg_len   [MAXSEG];
	bit seg_free  [MAXSEG];
	int seg_cnt;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int live_addrs[$];
	int errors = 0;
	bit stim_done = 0;
	int hold_off = 0;

	function automatic void arena_clear();
		seg_start[0] = 0;
		seg_len[0] = ARENA - HDR;
		seg_free[0] = 1;
		seg_cnt = 1;
	endfunction

	function automatic int seg_lookup(int a);
		if (a == 0) return -1;
		for (int i = 0; i < seg_cnt; i++)
			if (seg_start[i] + HDR == a) return i;
		return -1;
	endfunction

	function automatic int first_fit(int sz);
		for (int i = 0; i < seg_cnt; i++) begin
			if (seg_free[i] && seg_len[i] >= sz) begin
				if (seg_len[i] >= sz + HDR + 1 && seg_cnt < MAXSEG) begin
					for (int j = seg_cnt; j > i + 1; j--) begin
						seg_start[j] = seg_start[j-1];
						seg_len[j] = seg_len[j-1];
						seg_free[j] = seg_free[j-1];
					end
					seg_start[i+1] = seg_start[i] + HDR + sz;
					seg_len[i+1] = seg_len[i] - sz - HDR;
					seg_free[i+1] = 1;
					seg_len[i] = sz;
					seg_cnt++;
				end
				seg_free[i] = 0;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic rsp_t arena_predict(req_t r);
		rsp_t o;
		int a, sz, idx, n, old_len;
		o = '{addr: 0, st: ST_OK, moved: 0, copy: 0};
		a = r.addr;
		sz = r.size;
		if (r.op == OP_INIT) begin
			arena_clear();
		end else if (r.op == OP_ALLOC || (r.op == OP_RESIZE && a == 0)) begin
			idx = first_fit(sz);
			if (idx < 0) o.st = ST_NO_SPACE;
			else o.addr = 11'(seg_start[idx] + HDR);
		end else if (r.op == OP_RELEASE) begin
			if (a != 0) begin
				idx = seg_lookup(a);
				if (idx < 0) o.st = ST_BAD_ADDRESS;
				else seg_free[idx] = 1;
			end
		end else begin
			idx = seg_lookup(a);
			if (idx < 0) begin
				o.st = ST_BAD_ADDRESS;
			end else if (sz == 0) begin
				seg_free[idx] = 1;
			end else if (seg_len[idx] >= sz) begin
				o.addr = 11'(a);
			end else if (idx + 1 < seg_cnt && seg_free[idx+1] &&
					seg_len[idx] + HDR + seg_len[idx+1] >= sz) begin
				seg_len[idx] += HDR + seg_len[idx+1];
				for (int j = idx + 1; j < seg_cnt - 1; j++) begin
					seg_start[j] = seg_start[j+1];
					seg_len[j] = seg_len[j+1];
					seg_free[j] = seg_free[j+1];
				end
				seg_cnt--;
				o.addr = 11'(a);
			end else begin
				old_len = seg_len[idx];
				n = first_fit(sz);
				if (n < 0) begin
					o.st = ST_NO_SPACE;
				end else begin
					o.addr = 11'(seg_start[n] + HDR);
					idx = seg_lookup(a);
					if (idx >= 0) seg_free[idx] = 1;
					o.moved = 1;
					o.copy = 11'(old_len);
				end
			end
		end
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// mostly plausible sizes, sometimes anything in the field
	function automatic logic [15:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return 16'($urandom_range(1, 120));
		if (p < 85) return 16'($urandom_range(0, 600));
		if (p < 92) return 16'($urandom_range(0, 2047));
		return 16'($urandom);
	endfunction

	function automatic logic [10:0] rand_addr();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80 && live_addrs.size() > 0)
			return 11'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
		if (p < 85) return 11'd0;
		return 11'($urandom);
	endfunction

	// stimulus queue
	function automatic void push_req(op_t op, logic [10:0] a, logic [15:0] sz);
		pending_reqs.push_back('{op: op, addr: a, size: sz});
	endfunction

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_and_store(req_t'({s_tuser, s_tdata[10:0], s_tdata[26:11]}));
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 0;
				end else if (pending_reqs.size() > 0) begin
					req_t r;
					r = pending_reqs.pop_front();
					s_tvalid <= 1;
					s_tuser <= r.op;
					s_tdata <= {5'd0, r.size, r.addr};
					tx_gap <= gap_len();
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	task automatic predict_and_store(req_t r);
		rsp_t o;
		o = arena_predict(r);
		expected_rsps.push_back(o);
		if (o.addr != 0 && !(r.op == OP_RESIZE && o.addr == r.addr))
			live_addrs.push_back(o.addr);
		if (r.op == OP_INIT) live_addrs.delete();
		if (live_addrs.size() > 40) live_addrs.delete(0);
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				rsp_t got, exp_r;
				got = '{addr: m_tdata[10:0], st: status_t'(m_tdata[12:11]),
					moved: m_tdata[13], copy: m_tdata[24:14]};
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected transfer %h", $time, m_tdata);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (got.addr != exp_r.addr) begin
						$display("%0t: result_address exp %0d got %0d", $time, exp_r.addr, got.addr);
						errors++;
					end
					if (got.st != exp_r.st) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.st, got.st);
						errors++;
					end
					if (got.moved != exp_r.moved) begin
						$display("%0t: moved exp %0d got %0d", $time, exp_r.moved, got.moved);
						errors++;
					end
					if (got.copy != exp_r.copy) begin
						$display("%0t: copy_length exp %0d got %0d", $time, exp_r.copy, got.copy);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 0;
			end else begin
				m_tready <= (gap_len() == 0);
			end
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arena_clear();
		// directed
		push_req(OP_ALLOC, 11'd0, 16'd0);
		push_req(OP_ALLOC, 11'd0, 16'd100);
		push_req(OP_RELEASE, 11'd0, 16'd0);
		push_req(OP_RELEASE, 11'd5, 16'd0);
		push_req(OP_RELEASE, 11'h7FF, 16'hFFFF);
		push_req(OP_RESIZE, 11'd1, 16'd10);
		push_req(OP_RESIZE, 11'd24, 16'd50);
		push_req(OP_RESIZE, 11'd0, 16'd40);
		push_req(OP_RESIZE, 11'd24, 16'd300);
		push_req(OP_RESIZE, 11'd24, 16'd1000);
		push_req(OP_RELEASE, 11'd48, 16'd0);
		push_req(OP_RELEASE, 11'd48, 16'd0);
		push_req(OP_RESIZE, 11'd48, 16'd10);
		push_req(OP_RESIZE, 11'd24, 16'd0);
		push_req(OP_ALLOC, 11'd0, 16'hFFFF);
		push_req(OP_RESIZE, 11'd24, 16'hFFFF);
		push_req(OP_ALLOC, 11'd0, 16'd2024);
		push_req(OP_INIT, 11'h7FF, 16'hFFFF);
		push_req(OP_ALLOC, 11'd0, 16'd2024);
		push_req(OP_INIT, 11'd0, 16'd0);
		// allocate one-byte segments until the arena runs out of space
		for (int i = 0; i < 132; i++) push_req(OP_ALLOC, 11'd0, 16'd1);
		push_req(OP_INIT, 11'd0, 16'd0);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		for (int k = 0; k < 560; k++) begin
			int p;
			while (pending_reqs.size() > 4) @(posedge clk);
			p = $urandom_range(0, 99);
			if (k == 200) hold_off = 400;
			if (p < 40) push_req(OP_ALLOC, 11'($urandom), rand_size());
			else if (p < 65) push_req(OP_RELEASE, rand_addr(), 16'($urandom));
			else if (p < 97) push_req(OP_RESIZE, rand_addr(), rand_size());
			else push_req(OP_INIT, 11'($urandom), 16'($urandom));
		end
		while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
